// ----- rtl/core/bpa_pkg.sv -----
// Shared types, constants and codes for the bitmap page allocator.
// No dependencies; every other file of the block imports this package.
package bpa_pkg;

    localparam int ADDR_W     = 48;
    localparam int CNT_W      = 13;
    localparam int MAX_PAGES  = 4096;
    localparam int PAGE_SHIFT = 12;
    localparam int WORD_BITS  = 32;
    localparam int SCAN_BITS  = 8;
    localparam int WORDS      = MAX_PAGES / WORD_BITS;
    localparam int WORD_AW    = $clog2(WORDS);
    localparam int BIT_AW     = $clog2(WORD_BITS);
    localparam int BYTE_AW    = $clog2(WORD_BITS / SCAN_BITS);
    localparam int PIDX_W     = $clog2(MAX_PAGES);
    localparam int FIRST_W    = ADDR_W - PAGE_SHIFT;
    localparam int PDATA_W    = 64;
    localparam int PADDR_W    = 4;

    localparam logic [CNT_W-1:0] LIVE_MAX = CNT_W'(MAX_PAGES);
    localparam logic [CNT_W-1:0] CNT_MAX  = '1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_OUTSIDE  = 2'd2;

    localparam logic REG_BASE  = 1'b0;
    localparam logic REG_PAGES = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE_SUB,
        S_FREE_CHK,
        S_MARK_RD,
        S_MARK_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [CNT_W-1:0]  pages;
    } t_cfg;

    typedef struct packed {
        logic                 wr_en;
        logic [WORD_AW-1:0]   wr_addr;
        logic [WORD_BITS-1:0] wr_data;
        logic                 rd_en;
        logic [WORD_AW-1:0]   rd_addr;
    } t_ram_req;

    typedef struct packed {
        logic [CNT_W-1:0] start;
        logic [CNT_W-1:0] run;
    } t_run;

endpackage

// ----- rtl/core/bitmap_page_allocator_top.sv -----
// First-fit contiguous page allocator over one region with a 4096-page bitmap.
// Allocate walks the bitmap byte by byte (four bytes per 32-bit word, up to 512),
// then marks the found run word by word; free subtracts the base, checks the region
// and clears the run word by word. No-space allocates and refused or empty frees skip marking.
// One request at a time; the next is taken once the result has been registered at the output.
// After reset a clearing pass zeroes all 128 bitmap words; no request is taken until it ends.
module bitmap_page_allocator_top
    import bpa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_operation,
    input  logic [CNT_W-1:0]   i_page_count,
    input  logic [ADDR_W-1:0]  i_phys_address,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [ADDR_W-1:0]  o_address,
    output logic [1:0]         o_status,
    output logic [CNT_W-1:0]   o_used_pages,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg                 cfg;
    t_ram_req             ram_req;
    logic [WORD_BITS-1:0] ram_rd_data;

    bpa_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bpa_bitmap_ram u_bitmap (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (ram_rd_data)
    );

    bpa_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_page_count   (i_page_count),
        .i_phys_address (i_phys_address),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_address      (o_address),
        .o_status       (o_status),
        .o_used_pages   (o_used_pages),
        .o_ram_req      (ram_req),
        .i_rd_data      (ram_rd_data)
    );

endmodule

// ----- rtl/core/bpa_byte_scan.sv -----
// Run search step of the allocator: walks one byte of the used-page bitmap
// and extends or restarts the current free run. Depends on bpa_pkg.
module bpa_byte_scan
    import bpa_pkg::*;
(
    input  logic [SCAN_BITS-1:0] i_bits,
    input  logic [PIDX_W-1:0]    i_base,
    input  logic [CNT_W-1:0]     i_pages,
    input  logic [CNT_W-1:0]     i_count,
    input  t_run                 i_run,
    output t_run                 o_run,
    output logic                 o_found
);

    t_run             v_run;
    logic             v_found;
    logic [CNT_W-1:0] v_idx;

    // Pages at or beyond the live region size are not looked at, and the
    // walk stops at the first page that completes a run of the asked length.
    always_comb begin
        v_run   = i_run;
        v_found = 1'b0;
        v_idx   = '0;
        for (int k = 0; k < SCAN_BITS; k++) begin
            v_idx = {1'b0, i_base} + CNT_W'(k);
            if (!v_found && (v_idx < i_pages)) begin
                if (i_bits[k]) begin
                    v_run.start = v_idx + 1'b1;
                    v_run.run   = '0;
                end else begin
                    v_run.run = v_run.run + 1'b1;
                end
                if (v_run.run == i_count) begin
                    v_found = 1'b1;
                end
            end
        end
        o_run   = v_run;
        o_found = v_found;
    end

endmodule

// ----- rtl/core/bpa_bitmap_ram.sv -----
// Used-page bitmap storage: one write port and one read port with
// registered read data. Depends on bpa_pkg for widths and the request type.
module bpa_bitmap_ram
    import bpa_pkg::*;
(
    input  logic                 i_clk,
    input  t_ram_req             i_req,
    output logic [WORD_BITS-1:0] o_rd_data
);

    logic [WORD_BITS-1:0] r_mem [WORDS];
    logic [WORD_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/bpa_apb_regs.sv -----
// Configuration registers of the allocator behind an APB-style port.
// Depends on bpa_pkg for register codes and the configuration struct.
module bpa_apb_regs
    import bpa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [ADDR_W-1:0] r_base;
    logic [CNT_W-1:0]  r_pages;
    logic              wr_hit;
    logic              reg_sel;

    // Registers sit eight bytes apart, so one address bit picks the register.
    assign reg_sel = paddr[3];
    assign pready  = 1'b1;
    assign wr_hit  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_pages <= LIVE_MAX;
        end else if (wr_hit) begin
            if (reg_sel == REG_PAGES) begin
                r_pages <= pwdata[CNT_W-1:0];
            end else begin
                r_base <= pwdata[ADDR_W-1:0];
            end
        end
    end

    always_comb begin
        if (reg_sel == REG_PAGES) begin
            prdata = {{(PDATA_W-CNT_W){1'b0}}, r_pages};
        end else begin
            prdata = {{(PDATA_W-ADDR_W){1'b0}}, r_base};
        end
    end

    assign o_cfg.base  = r_base;
    assign o_cfg.pages = r_pages;

endmodule

// ----- rtl/core/bpa_ctrl.sv -----
// Sequencer of the allocator: bitmap clearing pass, byte-wise first-fit
// scan, region check for free requests, word-wise marking or clearing and the result
// register. Depends on bpa_pkg and bpa_byte_scan.
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_operation,
    input  logic [CNT_W-1:0]     i_page_count,
    input  logic [ADDR_W-1:0]    i_phys_address,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [ADDR_W-1:0]    o_address,
    output logic [1:0]           o_status,
    output logic [CNT_W-1:0]     o_used_pages,
    output t_ram_req             o_ram_req,
    input  logic [WORD_BITS-1:0] i_rd_data
);

    t_state             r_state, n_state;
    logic               r_op, n_op;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ADDR_W-1:0]  r_phys, n_phys;
    t_run               r_run, n_run;
    logic [WORD_AW-1:0] r_word, n_word;
    logic [BYTE_AW-1:0] r_byte, n_byte;
    logic [CNT_W-1:0]   r_end, n_end;
    logic [ADDR_W-1:0]  r_diff, n_diff;
    logic               r_borrow, n_borrow;
    logic [ADDR_W-1:0]  r_res_addr, n_res_addr;
    logic [1:0]         r_res_status, n_res_status;
    logic [CNT_W-1:0]   r_used, n_used;
    logic               r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]  r_out_addr, n_out_addr;
    logic [1:0]         r_out_status, n_out_status;
    logic [CNT_W-1:0]   r_out_used, n_out_used;

    logic [CNT_W-1:0]     pages;
    logic [PIDX_W-1:0]    scan_base;
    logic [CNT_W-1:0]     next_base;
    logic [SCAN_BITS-1:0] scan_bits;
    t_run                 scan_run;
    logic                 scan_found;
    logic [WORD_BITS-1:0] mark_mask;
    logic [CNT_W-1:0]     mask_idx;
    logic                 last_word;
    logic [FIRST_W-1:0]   first_page;
    logic [FIRST_W:0]     free_end;
    logic [CNT_W:0]       alloc_sum;
    logic [CNT_W-1:0]     alloc_used;
    logic [CNT_W-1:0]     free_used;

    assign pages = (i_cfg.pages > LIVE_MAX) ? LIVE_MAX : i_cfg.pages;

    assign scan_base = {r_word, r_byte, {(BIT_AW-BYTE_AW){1'b0}}};
    assign next_base = {1'b0, scan_base} + CNT_W'(SCAN_BITS);
    assign scan_bits = i_rd_data[{r_byte, {(BIT_AW-BYTE_AW){1'b0}}} +: SCAN_BITS];

    bpa_byte_scan u_byte_scan (
        .i_bits  (scan_bits),
        .i_base  (scan_base),
        .i_pages (pages),
        .i_count (r_count),
        .i_run   (r_run),
        .o_run   (scan_run),
        .o_found (scan_found)
    );

    // Bits of the current word that fall inside the run being marked or freed.
    always_comb begin
        mark_mask = '0;
        mask_idx  = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            mask_idx     = {1'b0, r_word, BIT_AW'(j)};
            mark_mask[j] = (mask_idx >= r_run.start) && (mask_idx < r_end);
        end
    end

    assign last_word = ({1'b0, r_word, {BIT_AW{1'b0}}} + CNT_W'(WORD_BITS)) >= r_end;

    assign first_page = r_diff[ADDR_W-1:PAGE_SHIFT];
    assign free_end   = {1'b0, first_page} + (FIRST_W+1)'(r_count);

    assign alloc_sum  = {1'b0, r_used} + {1'b0, r_count};
    assign alloc_used = alloc_sum[CNT_W] ? CNT_MAX : alloc_sum[CNT_W-1:0];
    assign free_used  = (r_used > r_count) ? (r_used - r_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_word      <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_word      <= n_word;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_count      <= n_count;
        r_phys       <= n_phys;
        r_run        <= n_run;
        r_byte       <= n_byte;
        r_end        <= n_end;
        r_diff       <= n_diff;
        r_borrow     <= n_borrow;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
        r_out_used   <= n_out_used;
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_count      = r_count;
        n_phys       = r_phys;
        n_run        = r_run;
        n_word       = r_word;
        n_byte       = r_byte;
        n_end        = r_end;
        n_diff       = r_diff;
        n_borrow     = r_borrow;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_used       = r_used;
        n_out_valid  = r_out_valid;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        n_out_used   = r_out_used;
        o_in_ready   = 1'b0;

        o_ram_req         = '0;
        o_ram_req.wr_addr = r_word;
        o_ram_req.rd_addr = r_word;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                o_ram_req.wr_en   = 1'b1;
                o_ram_req.wr_data = '0;
                n_word            = r_word + 1'b1;
                if (r_word == WORD_AW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op    = i_operation;
                    n_count = i_page_count;
                    n_phys  = i_phys_address;
                    if (i_operation == OP_FREE) begin
                        n_state = S_FREE_SUB;
                    end else if (i_page_count == '0) begin
                        n_res_addr   = '0;
                        n_res_status = ST_NO_SPACE;
                        n_state      = S_DONE;
                    end else begin
                        o_ram_req.rd_en   = 1'b1;
                        o_ram_req.rd_addr = '0;
                        n_word            = '0;
                        n_byte            = '0;
                        n_run             = '0;
                        n_state           = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                n_run = scan_run;
                if (scan_found) begin
                    n_end   = scan_run.start + r_count;
                    n_word  = scan_run.start[PIDX_W-1:BIT_AW];
                    n_state = S_MARK_RD;
                end else if (next_base >= pages) begin
                    n_res_addr   = '0;
                    n_res_status = ST_NO_SPACE;
                    n_state      = S_DONE;
                end else if (&r_byte) begin
                    // Fetch the next word while the last byte of this one is walked.
                    o_ram_req.rd_en   = 1'b1;
                    o_ram_req.rd_addr = r_word + 1'b1;
                    n_word            = r_word + 1'b1;
                    n_byte            = '0;
                end else begin
                    n_byte = r_byte + 1'b1;
                end
            end

            S_FREE_SUB: begin
                {n_borrow, n_diff} = {1'b0, r_phys} - {1'b0, i_cfg.base};
                n_state            = S_FREE_CHK;
            end

            S_FREE_CHK: begin
                if (r_borrow || (free_end > (FIRST_W+1)'(pages))) begin
                    n_res_addr   = '0;
                    n_res_status = ST_OUTSIDE;
                    n_state      = S_DONE;
                end else if (r_count == '0) begin
                    n_res_addr   = '0;
                    n_res_status = ST_OK;
                    n_state      = S_DONE;
                end else begin
                    n_run.start = first_page[CNT_W-1:0];
                    n_end       = first_page[CNT_W-1:0] + r_count;
                    n_word      = first_page[PIDX_W-1:BIT_AW];
                    n_state     = S_MARK_RD;
                end
            end

            S_MARK_RD: begin
                o_ram_req.rd_en = 1'b1;
                n_state         = S_MARK_WR;
            end

            S_MARK_WR: begin
                o_ram_req.wr_en = 1'b1;
                if (r_op == OP_ALLOC) begin
                    o_ram_req.wr_data = i_rd_data | mark_mask;
                end else begin
                    o_ram_req.wr_data = i_rd_data & ~mark_mask;
                end
                if (last_word) begin
                    n_res_status = ST_OK;
                    if (r_op == OP_ALLOC) begin
                        n_used     = alloc_used;
                        n_res_addr = i_cfg.base + (ADDR_W'(r_run.start) << PAGE_SHIFT);
                    end else begin
                        n_used     = free_used;
                        n_res_addr = '0;
                    end
                    n_state = S_DONE;
                end else begin
                    o_ram_req.rd_en   = 1'b1;
                    o_ram_req.rd_addr = r_word + 1'b1;
                    n_word            = r_word + 1'b1;
                end
            end

            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = r_res_addr;
                    n_out_status = r_res_status;
                    n_out_used   = r_used;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_address    = r_out_addr;
    assign o_status     = r_out_status;
    assign o_used_pages = r_out_used;

endmodule
